/* hdl/frx_pkg.sv */
`timescale 1ns / 1ps

package frx_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 9;
  localparam int unsigned LenW    = 9;
  localparam int unsigned StatusW = 3;
  localparam int unsigned KindW   = 2;

  // Stream packing: tdata = {pad, byte_position, data_byte}
  localparam int unsigned OutDataW = 24;
  localparam int unsigned OutPadW  = OutDataW - ByteW - PosW;
  // tuser = {want_extra_poll, response_kind, frame_status, in_frame}
  localparam int unsigned OutUserW = 1 + StatusW + KindW + 1;

  // Protocol bytes
  localparam logic [ByteW-1:0] StartA     = 8'h31;
  localparam logic [ByteW-1:0] StartB     = 8'h71;
  localparam logic [ByteW-1:0] StartC     = 8'hF1;
  localparam logic [ByteW-1:0] HdrOne     = 8'h01;
  localparam logic [ByteW-1:0] TypeStd    = 8'h10;
  localparam logic [ByteW-1:0] TypeExtra  = 8'h21;
  localparam logic [ByteW-1:0] PollLimit  = 8'h02;
  localparam logic [PosW-1:0]  PosLen     = 9'd1;
  localparam logic [PosW-1:0]  PosHdr     = 9'd2;
  localparam logic [PosW-1:0]  PosType    = 9'd3;
  localparam logic [PosW-1:0]  PosPollFlg = 9'd199;
  localparam logic [LenW-1:0]  LenExtra   = 9'd3;
  localparam logic [LenW-1:0]  ExpLenRst  = 9'd203;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_OK     = 2'd1,
    PH_FLAWED = 2'd2
  } phase_t;

  typedef enum logic [StatusW-1:0] {
    ST_BUSY      = 3'd0,
    ST_GOOD      = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_HDR   = 3'd3,
    ST_BAD_SUM   = 3'd4
  } status_t;

  typedef enum logic [KindW-1:0] {
    KIND_NONE  = 2'd0,
    KIND_STD   = 2'd1,
    KIND_EXTRA = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  typedef struct packed {
    logic              want_extra_poll;
    kind_t             response_kind;
    status_t           frame_status;
    logic              frame_end;
    logic              in_frame;
    logic [PosW-1:0]   byte_position;
    logic [ByteW-1:0]  data_byte;
  } frx_result_t;

endpackage

/* hdl/frx_in_stage.sv */
`timescale 1ns / 1ps

module frx_in_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [frx_pkg::ByteW-1:0] in_tdata,   // [7:0] rx_byte
  input  logic                     pop,
  output logic                     valid,
  output logic [frx_pkg::ByteW-1:0] rx_byte
);
  import frx_pkg::*;

  logic             valid_r, valid_nxt;
  logic [ByteW-1:0] byte_r;
  logic             take;

  // Take a word whenever the register is empty or drains this cycle
  assign in_tready = !valid_r || pop;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    priority if (take) begin
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the byte until it is processed
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_tdata;
    end
  end

  assign valid   = valid_r;
  assign rx_byte = byte_r;

endmodule

/* hdl/frx_core.sv */
`timescale 1ns / 1ps

module frx_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  logic [frx_pkg::ByteW-1:0] rx_byte,
  input  logic [frx_pkg::LenW-1:0]  exp_len,
  output frx_pkg::frx_result_t      res
);
  import frx_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [PosW-1:0]  count_r, count_nxt;
  logic [LenW-1:0]  total_r, total_nxt;
  logic [ByteW-1:0] sum_r, sum_nxt;
  logic [ByteW-1:0] type_r, type_nxt;
  logic [ByteW-1:0] extra_r, extra_nxt;

  logic             is_start;
  logic             hdr_flaw;
  logic             flawed_now;
  logic             end_flaw;
  logic             end_len;
  logic [ByteW-1:0] sum_add;
  logic [ByteW-1:0] type_cur;
  logic [ByteW-1:0] extra_cur;
  logic [LenW-1:0]  len_from_byte;

  // Decode the current byte against the frame position
  assign is_start = (rx_byte == StartA) || (rx_byte == StartB) || (rx_byte == StartC);
  assign hdr_flaw = ((count_r == PosLen) && (rx_byte == '0)) ||
                    ((count_r == PosHdr) && (rx_byte != HdrOne) && (rx_byte != TypeStd)) ||
                    ((count_r == PosType) && (rx_byte != HdrOne) && (rx_byte != TypeStd) &&
                     (rx_byte != TypeExtra));
  assign flawed_now    = (phase_r == PH_FLAWED) || hdr_flaw;
  assign end_flaw      = (count_r == PosType) && flawed_now;
  assign end_len       = !end_flaw && (count_r >= PosType) &&
                         (({1'b0, count_r} + 10'd1) >= {1'b0, total_r});
  assign sum_add       = sum_r + rx_byte;
  assign type_cur      = (count_r == PosType) ? rx_byte : type_r;
  assign extra_cur     = (count_r == PosPollFlg) ? rx_byte : extra_r;
  assign len_from_byte = {1'b0, rx_byte} + LenExtra;

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    total_nxt = total_r;
    sum_nxt   = sum_r;
    type_nxt  = type_r;
    extra_nxt = extra_r;
    if (fire) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (is_start) begin
            phase_nxt = PH_OK;
            count_nxt = PosLen;
            sum_nxt   = rx_byte;
            total_nxt = '0;
            type_nxt  = '0;
            extra_nxt = '0;
          end
        end
        PH_OK, PH_FLAWED: begin
          sum_nxt = sum_add;
          if (count_r == PosLen) begin
            total_nxt = len_from_byte;
          end
          if (count_r == PosType) begin
            type_nxt = rx_byte;
          end
          if (count_r == PosPollFlg) begin
            extra_nxt = rx_byte;
          end
          if (end_flaw || end_len) begin
            phase_nxt = PH_HUNT;
          end else begin
            phase_nxt = flawed_now ? PH_FLAWED : phase_r;
            count_nxt = count_r + PosLen;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  // Result fields for the current byte
  always_comb begin
    res                 = '0;
    res.data_byte       = rx_byte;
    res.frame_status    = ST_BUSY;
    res.response_kind   = KIND_NONE;
    unique case (phase_r)
      PH_HUNT: begin
        if (is_start) begin
          res.in_frame = 1'b1;
        end else begin
          res.frame_end    = 1'b1;
          res.frame_status = ST_BAD_START;
        end
      end
      PH_OK, PH_FLAWED: begin
        res.byte_position = count_r;
        res.in_frame      = 1'b1;
        if (end_flaw) begin
          res.frame_end    = 1'b1;
          res.frame_status = ST_BAD_HDR;
        end else if (end_len) begin
          res.frame_end = 1'b1;
          if (sum_add != '0) begin
            res.frame_status = ST_BAD_SUM;
          end else begin
            res.frame_status = ST_GOOD;
            priority if (total_r != exp_len) begin
              res.response_kind = KIND_OTHER;
            end else if (type_cur == TypeStd) begin
              res.response_kind   = KIND_STD;
              res.want_extra_poll = extra_cur > PollLimit;
            end else if (type_cur == TypeExtra) begin
              res.response_kind = KIND_EXTRA;
            end else begin
              res.response_kind = KIND_OTHER;
            end
          end
        end
      end
      default: begin
        res.frame_status = ST_BUSY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= '0;
      total_r <= '0;
      sum_r   <= '0;
      type_r  <= '0;
      extra_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
      sum_r   <= sum_nxt;
      type_r  <= type_nxt;
      extra_r <= extra_nxt;
    end
  end

endmodule

/* hdl/frx_out_stage.sv */
`timescale 1ns / 1ps

module frx_out_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  frx_pkg::frx_result_t         res,
  output logic                         free,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [frx_pkg::OutDataW-1:0] out_tdata,  // [7:0] data_byte, [16:8] byte_position
  output logic                         out_tlast,  // frame_end
  // [0] in_frame, [3:1] frame_status, [5:4] response_kind, [6] want_extra_poll
  output logic [frx_pkg::OutUserW-1:0] out_tuser
);
  import frx_pkg::*;

  logic        valid_r, valid_nxt;
  frx_result_t res_r;

  // Room for a new word when empty or when the current one leaves now
  assign free = !valid_r || out_tready;

  always_comb begin
    priority if (push) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  // Pack the stream word
  assign out_tvalid = valid_r;
  assign out_tdata  = {{OutPadW{1'b0}}, res_r.byte_position, res_r.data_byte};
  assign out_tlast  = res_r.frame_end;
  assign out_tuser  = {res_r.want_extra_poll, res_r.response_kind,
                       res_r.frame_status, res_r.in_frame};

endmodule

/* hdl/length_checksum_frame_receiver_unit.sv */
`timescale 1ns / 1ps

// Frame receiver for a length-and-checksum serial protocol. Every received byte
// gives exactly one output word: the byte, its position in the frame and the
// frame flags; tlast marks the byte that completes or drops a frame, with the
// status and, for a good frame, its response class in tuser. Throughput is one
// byte per clock while out_tready is held high; the byte passes an input register and
// then the result register, with the frame state updated in the single step between
// them. in_tready follows out_tready combinationally when both registers are
// full. The expected response length may be written on the cfg port at any
// time the receiver is idle; it resets to 203.
module length_checksum_frame_receiver_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [frx_pkg::ByteW-1:0]    in_tdata,   // [7:0] rx_byte
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [frx_pkg::OutDataW-1:0] out_tdata,  // [7:0] data_byte, [16:8] byte_position
  output logic                         out_tlast,  // frame_end
  // [0] in_frame, [3:1] frame_status, [5:4] response_kind, [6] want_extra_poll
  output logic [frx_pkg::OutUserW-1:0] out_tuser,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [frx_pkg::LenW-1:0]     cfg_data    // expected_response_length
);
  import frx_pkg::*;

  logic             byte_valid;
  logic [ByteW-1:0] rx_byte;
  logic             out_free;
  logic             fire;
  frx_result_t      res;
  logic [LenW-1:0]  exp_len_r;

  // Advance when a byte waits and the result register has room
  assign fire = byte_valid && out_free;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= ExpLenRst;
    end else if (cfg_valid && cfg_ready) begin
      exp_len_r <= cfg_data;
    end
  end

  frx_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .pop       (fire),
    .valid     (byte_valid),
    .rx_byte   (rx_byte)
  );

  frx_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (rx_byte),
    .exp_len (exp_len_r),
    .res     (res)
  );

  frx_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* tb/tb_length_checksum_frame_receiver_unit.sv */
`timescale 1ns / 1ps

module tb_length_checksum_frame_receiver_unit;
  import frx_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int HoldOffCycles = 80;
  localparam int PhaseBytes    = 30;
  localparam int DrainCycles   = 10;
  localparam int ReportLimit   = 10;
  localparam int MaxFrame      = 258;

  // One echoed word as the receiver should report it
  typedef struct packed {
    logic             poll;
    kind_t            kind;
    status_t          status;
    logic             fend;
    logic             inf;
    logic [PosW-1:0]  pos;
    logic [ByteW-1:0] data;
  } echo_t;

  // Directed row: byte to send, and a hand-written expectation when typed is set
  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic             typed;
    logic [PosW-1:0]  pos;
    logic             inf;
    logic             fend;
    status_t          status;
    kind_t            kind;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [ByteW-1:0]    in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;
  logic [OutUserW-1:0] out_tuser;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [LenW-1:0]     cfg_data;

  // Receiver copy: frame state and the response length register
  phase_t           rx_phase;
  logic [PosW-1:0]  rx_count;
  logic [LenW-1:0]  rx_total;
  logic [LenW-1:0]  resp_len;
  logic [ByteW-1:0] rx_sum;
  logic [ByteW-1:0] rx_type;
  logic [ByteW-1:0] rx_flag;

  echo_t echo_q[$];
  int    mismatches = 0;
  int    quiet = 0;
  bit    steady;
  bit    stall_go;

  // Bad start bytes, header flaws, a zero length, a four byte frame, a good short frame
  dir_row_t dir_rows [24] = '{
    '{8'h00,     1'b1, 9'd0, 1'b0, 1'b1, ST_BAD_START, KIND_NONE},
    '{8'hFF,     1'b1, 9'd0, 1'b0, 1'b1, ST_BAD_START, KIND_NONE},
    '{StartA,    1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{8'h00,     1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{HdrOne,    1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{TypeStd,   1'b1, 9'd3, 1'b1, 1'b1, ST_BAD_HDR,   KIND_NONE},
    '{StartB,    1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{8'h01,     1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{HdrOne,    1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{TypeStd,   1'b1, 9'd3, 1'b1, 1'b1, ST_BAD_SUM,   KIND_NONE},
    '{StartC,    1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{8'h05,     1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{8'h02,     1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{TypeStd,   1'b1, 9'd3, 1'b1, 1'b1, ST_BAD_HDR,   KIND_NONE},
    '{StartA,    1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{8'h05,     1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{TypeStd,   1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{8'h22,     1'b1, 9'd3, 1'b1, 1'b1, ST_BAD_HDR,   KIND_NONE},
    '{StartA,    1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{8'h02,     1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{TypeStd,   1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{TypeExtra, 1'b0, 9'd0, 1'b0, 1'b0, ST_BUSY,      KIND_NONE},
    '{8'h9C,     1'b1, 9'd4, 1'b1, 1'b1, ST_GOOD,      KIND_OTHER},
    '{8'h30,     1'b1, 9'd0, 1'b0, 1'b1, ST_BAD_START, KIND_NONE}
  };

  length_checksum_frame_receiver_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the receiver copy by one byte and return the word it should echo
  function automatic echo_t frame_step(input logic [ByteW-1:0] b);
    echo_t           r;
    logic [PosW-1:0] at;
    r = '0;
    r.data = b;
    if (rx_phase == PH_HUNT) begin
      if (b == StartA || b == StartB || b == StartC) begin
        rx_phase = PH_OK;
        rx_count = 9'd1;
        rx_sum   = b;
        rx_total = '0;
        rx_type  = '0;
        rx_flag  = '0;
        r.inf    = 1'b1;
      end else begin
        r.fend   = 1'b1;
        r.status = ST_BAD_START;
      end
    end else begin
      at     = rx_count;
      r.pos  = at;
      r.inf  = 1'b1;
      rx_sum = rx_sum + b;
      // Header bytes are checked here, the verdict falls at the type byte
      if (at == PosLen) begin
        rx_total = LenW'(b) + LenExtra;
        if (b == '0) rx_phase = PH_FLAWED;
      end else if (at == PosHdr) begin
        if (b != HdrOne && b != TypeStd) rx_phase = PH_FLAWED;
      end else if (at == PosType) begin
        rx_type = b;
        if (b != HdrOne && b != TypeStd && b != TypeExtra) rx_phase = PH_FLAWED;
      end else if (at == PosPollFlg) begin
        rx_flag = b;
      end
      if (at == PosType && rx_phase == PH_FLAWED) begin
        r.fend   = 1'b1;
        r.status = ST_BAD_HDR;
        rx_phase = PH_HUNT;
      end else if (at >= PosType && int'(at) + 1 >= int'(rx_total)) begin
        // Last byte: judge the checksum, then class a good frame
        r.fend   = 1'b1;
        rx_phase = PH_HUNT;
        if (rx_sum != '0) begin
          r.status = ST_BAD_SUM;
        end else begin
          r.status = ST_GOOD;
          if (rx_total != resp_len) begin
            r.kind = KIND_OTHER;
          end else if (rx_type == TypeStd) begin
            r.kind = KIND_STD;
            r.poll = (rx_flag > PollLimit);
          end else if (rx_type == TypeExtra) begin
            r.kind = KIND_EXTRA;
          end else begin
            r.kind = KIND_OTHER;
          end
        end
      end else begin
        rx_count = rx_count + 1'b1;
      end
    end
    return r;
  endfunction

  // Offer one byte after an optional idle gap, and record its expected word once taken
  task automatic push_byte(input logic [ByteW-1:0] b, input bit typed, input echo_t want);
    echo_t predicted;
    if (!steady && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 25);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    predicted = frame_step(b);
    echo_q.push_back(typed ? want : predicted);
  endtask

  task automatic note_mismatch(input string why, input echo_t want, input echo_t got);
    mismatches++;
    if (mismatches <= ReportLimit) begin
      $display("%0t %s: exp byte %h pos %0d inf %b end %b st %0d kind %0d poll %b",
               $realtime, why, want.data, want.pos, want.inf, want.fend, want.status,
               want.kind, want.poll);
      $display("    got byte %h pos %0d inf %b end %b st %0d kind %0d poll %b",
               got.data, got.pos, got.inf, got.fend, got.status, got.kind, got.poll);
    end
  endtask

  // Output side: check each word, then pick the next ready with stalls and one long hold
  initial begin : drain_side
    int    hold;
    bit    held;
    echo_t got;
    echo_t want;
    hold = 0;
    held = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.data   = out_tdata[ByteW-1:0];
        got.pos    = out_tdata[ByteW +: PosW];
        got.fend   = out_tlast;
        got.inf    = out_tuser[0];
        got.status = status_t'(out_tuser[3:1]);
        got.kind   = kind_t'(out_tuser[5:4]);
        got.poll   = out_tuser[6];
        if (echo_q.size() == 0) begin
          note_mismatch("word with nothing expected", '0, got);
        end else begin
          want = echo_q.pop_front();
          if (got.data !== want.data || got.pos !== want.pos || got.inf !== want.inf ||
              got.fend !== want.fend || got.status !== want.status ||
              got.kind !== want.kind || got.poll !== want.poll)
            note_mismatch("field mismatch", want, got);
        end
      end
      if (stall_go && !held) begin
        hold = HoldOffCycles;
        held = 1'b1;
      end
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 25);
      end
    end
  end

  // Watchdog: end the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Input side: reset, directed table, then random frames under several length settings
  initial begin : feed_side
    logic [ByteW-1:0] fr [MaxFrame];
    logic [ByteW-1:0] acc;
    logic [LenW-1:0]  len_cfg [6];
    int               p;
    int               i;
    int               sent;
    int               pick;
    int               flen;
    int               cut;
    echo_t            want;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    steady   = 1'b0;
    stall_go = 1'b0;
    rx_phase = PH_HUNT;
    rx_count = '0;
    rx_total = '0;
    rx_sum   = '0;
    rx_type  = '0;
    rx_flag  = '0;
    resp_len = ExpLenRst;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table at the reset length setting
    foreach (dir_rows[k]) begin
      want        = '0;
      want.data   = dir_rows[k].rx;
      want.pos    = dir_rows[k].pos;
      want.inf    = dir_rows[k].inf;
      want.fend   = dir_rows[k].fend;
      want.status = dir_rows[k].status;
      want.kind   = dir_rows[k].kind;
      push_byte(dir_rows[k].rx, dir_rows[k].typed, want);
    end

    len_cfg    = '{9'd5, 9'd258, ExpLenRst, 9'd0, 9'd0, 9'd511};
    len_cfg[3] = LenW'($urandom_range(5, 40));

    foreach (len_cfg[q]) begin
      p = q;
      // Hold input and let every word drain before touching the length register
      in_tvalid <= 1'b0;
      while (echo_q.size() != 0) @(posedge clk);
      cfg_valid <= 1'b1;
      cfg_data  <= len_cfg[p];
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      resp_len = len_cfg[p];

      stall_go = stall_go || (p == 1);
      steady   = (p == 2);
      sent     = 0;
      while (sent < PhaseBytes) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          // Line noise between frames
          push_byte(ByteW'($urandom_range(255)), 1'b0, '0);
          sent++;
        end else begin
          if (pick < 55 && len_cfg[p] >= 4 && len_cfg[p] <= MaxFrame)
            flen = len_cfg[p];
          else if ($urandom_range(99) < 8)
            flen = $urandom_range(200, 210);
          else
            flen = $urandom_range(4, 12);
          case ($urandom_range(2))
            0:       fr[0] = StartA;
            1:       fr[0] = StartB;
            default: fr[0] = StartC;
          endcase
          fr[1] = ByteW'(flen - 3);
          fr[2] = $urandom_range(1) ? HdrOne : TypeStd;
          case ($urandom_range(3))
            0:       fr[3] = HdrOne;
            3:       fr[3] = TypeExtra;
            default: fr[3] = TypeStd;
          endcase
          for (i = 4; i < flen; i++) fr[i] = ByteW'($urandom_range(255));
          // Keep the poll flag byte near its threshold half the time
          if (flen > PosPollFlg && $urandom_range(1)) fr[PosPollFlg] = ByteW'($urandom_range(4));
          // Close the checksum on the last byte of frames longer than four bytes
          acc = '0;
          for (i = 0; i < flen - 1; i++) acc = acc + fr[i];
          if (flen > 4) fr[flen-1] = 8'd0 - acc;
          // Break some frames: flip a bit or cut the frame short
          if ($urandom_range(99) < 12) begin
            i = $urandom_range(flen - 1);
            fr[i] = fr[i] ^ ByteW'(1 << $urandom_range(7));
          end
          cut = ($urandom_range(99) < 6) ? $urandom_range(1, flen - 1) : flen;
          for (i = 0; i < cut; i++) push_byte(fr[i], 1'b0, '0);
          sent += cut;
        end
      end
    end

    in_tvalid <= 1'b0;
    while (echo_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
